/* hw/rtl/positional_array_list_defines.svh */
// Assertion macros for the positional array list.
// Each macro expects clk and rst_n in scope.
`ifndef POSITIONAL_ARRAY_LIST_DEFINES_SVH
`define POSITIONAL_ARRAY_LIST_DEFINES_SVH

`ifndef ASSERT_OFF

`define PAL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define PAL_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define PAL_ASSERT(lbl, prop, msg)

`define PAL_NEVER(lbl, cond, msg)

`endif

`endif

/* hw/rtl/pal_pkg.sv */
package pal_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_GET    = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_NULL  = 2'd3
    } status_t;

    localparam int CAP_WIDTH = 7;
    localparam logic [CAP_WIDTH-1:0] CAP_RESET = 7'd64;

    localparam int POS_WIDTH = 6;
    localparam int VAL_WIDTH = 32;

endpackage

/* hw/rtl/pal_ram.sv */
module pal_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/positional_array_list.sv */
// Positional array list engine.
// Command channel: present command, position and value with start high; the
// transfer happens at a rising edge where start is high and busy is low.
// Result channel: done pulses for one cycle with ok, status, read_value and
// list_length; the receiver must take it in that cycle (no back-pressure).
// Configuration: cfg_write_en writes cfg_write_data into the capacity limit
// at once; write it only while the block is idle.
// Command flow, n = list length, p = position:
//   rejected command or clear      : answered straight from idle
//   get                            : fetch, then result
//   delete                         : fetch, n - p - 1 moves, drain;
//                                    fetch only for the last entry
//   insert                         : n - p moves, drain, place (append: place)
// Shifting moves one entry per cycle through the single-port-write store.
// busy stays high until the result is issued; one command is in flight at a
// time, and the next command may transfer in the cycle where done is high.
// Reset empties the list and sets the capacity limit to 64; the store
// contents are left as they are and need no clearing pass.
`include "positional_array_list_defines.svh"

module positional_array_list #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  pal_pkg::cmd_t                      command,
    input  logic [pal_pkg::POS_WIDTH-1:0]      position,
    input  logic [pal_pkg::VAL_WIDTH-1:0]      value,
    output logic                               done,
    output logic                               ok,
    output pal_pkg::status_t                   status,
    output logic [pal_pkg::VAL_WIDTH-1:0]      read_value,
    output logic [pal_pkg::CAP_WIDTH-1:0]      list_length,
    input  logic                               cfg_write_en,
    input  logic [pal_pkg::CAP_WIDTH-1:0]      cfg_write_data
);

    import pal_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > CAP_WIDTH) ? CW : CAP_WIDTH;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_MOVE,
        S_DRAIN,
        S_PLACE
    } state_t;

    state_t                state_reg;
    logic [CW-1:0]         count_reg;
    logic [CAP_WIDTH-1:0]  cap_reg;
    logic                  done_reg;
    logic                  pend_reg;

    cmd_t                  cmd_reg;
    logic [AW-1:0]         pos_reg;
    logic [DATA_WIDTH-1:0] val_reg;
    logic [AW-1:0]         rp_reg;
    logic [AW-1:0]         last_reg;
    logic [AW-1:0]         wa_reg;
    logic                  up_reg;
    logic                  shift_reg;
    logic [DATA_WIDTH-1:0] hold_reg;
    logic                  ok_reg;
    status_t               status_reg;
    logic [VAL_WIDTH-1:0]  read_reg;

    logic [PW-1:0]         pos_x;
    logic [PW-1:0]         count_x;
    logic [PW-1:0]         cap_x;
    logic [PW-1:0]         depth_x;
    logic [PW-1:0]         eff_cap;
    logic [PW-1:0]         pins_x;
    logic [PW-1:0]         cnt_m1_x;
    logic [PW-1:0]         pos_p1_x;
    logic [DATA_WIDTH+VAL_WIDTH-1:0] val_ext;
    logic [DATA_WIDTH+VAL_WIDTH-1:0] rd_ext;
    logic [DATA_WIDTH+VAL_WIDTH-1:0] hold_ext;
    logic [DATA_WIDTH-1:0] val_w;
    logic                  val_zero;
    logic                  list_full;
    logic                  range_bad;
    logic                  accept;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    assign busy        = (state_reg != S_IDLE);
    assign accept      = start && !busy;
    assign done        = done_reg;
    assign ok          = ok_reg;
    assign status      = status_reg;
    assign read_value  = read_reg;
    assign list_length = CAP_WIDTH'(count_reg);

    always_comb
    begin
        pos_x     = PW'(position);
        count_x   = PW'(count_reg);
        cap_x     = PW'(cap_reg);
        depth_x   = PW'(DEPTH);
        eff_cap   = (cap_x > depth_x) ? depth_x : cap_x;
        pins_x    = (pos_x > count_x) ? count_x : pos_x;
        cnt_m1_x  = count_x - PW'(1);
        pos_p1_x  = pos_x + PW'(1);
        val_ext   = {{DATA_WIDTH{1'b0}}, value};
        val_w     = val_ext[DATA_WIDTH-1:0];
        rd_ext    = {{VAL_WIDTH{1'b0}}, ram_rdata};
        hold_ext  = {{VAL_WIDTH{1'b0}}, hold_reg};
        val_zero  = (val_w == '0);
        list_full = (count_x >= eff_cap);
        range_bad = (pos_x >= count_x);
    end

    // Store port: read the command position while idle, else the move pointer.
    always_comb
    begin
        ram_raddr = (state_reg == S_IDLE) ? pos_x[AW-1:0] : rp_reg;
        ram_we    = ((state_reg == S_MOVE) && pend_reg) || (state_reg == S_DRAIN)
                    || (state_reg == S_PLACE);
        ram_waddr = (state_reg == S_PLACE) ? pos_reg : wa_reg;
        ram_wdata = (state_reg == S_PLACE) ? val_reg : ram_rdata;
    end

    pal_ram #(
        .DEPTH (DEPTH),
        .WIDTH (DATA_WIDTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            cap_reg    <= CAP_RESET;
            done_reg   <= 1'b0;
            pend_reg   <= 1'b0;
            cmd_reg    <= CMD_INSERT;
            pos_reg    <= '0;
            val_reg    <= '0;
            rp_reg     <= '0;
            last_reg   <= '0;
            wa_reg     <= '0;
            up_reg     <= 1'b0;
            shift_reg  <= 1'b0;
            hold_reg   <= '0;
            ok_reg     <= 1'b0;
            status_reg <= ST_OK;
            read_reg   <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                cap_reg <= cfg_write_data;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg   <= command;
                        val_reg   <= val_w;
                        up_reg    <= (command == CMD_INSERT);
                        shift_reg <= (pos_p1_x < count_x);
                        read_reg  <= '0;
                        if (command == CMD_INSERT)
                        begin
                            pos_reg  <= pins_x[AW-1:0];
                            rp_reg   <= cnt_m1_x[AW-1:0];
                            last_reg <= pins_x[AW-1:0];
                        end
                        else
                        begin
                            pos_reg  <= pos_x[AW-1:0];
                            rp_reg   <= pos_p1_x[AW-1:0];
                            last_reg <= cnt_m1_x[AW-1:0];
                        end
                        case (command)
                            CMD_INSERT:
                            begin
                                if (val_zero)
                                begin
                                    done_reg   <= 1'b1;
                                    ok_reg     <= 1'b0;
                                    status_reg <= ST_NULL;
                                end
                                else if (list_full)
                                begin
                                    done_reg   <= 1'b1;
                                    ok_reg     <= 1'b0;
                                    status_reg <= ST_FULL;
                                end
                                else if (pins_x == count_x)
                                begin
                                    done_reg   <= 1'b0;
                                    ok_reg     <= 1'b0;
                                    status_reg <= ST_OK;
                                    state_reg  <= S_PLACE;
                                end
                                else
                                begin
                                    done_reg   <= 1'b0;
                                    ok_reg     <= 1'b0;
                                    status_reg <= ST_OK;
                                    state_reg  <= S_MOVE;
                                    pend_reg   <= 1'b0;
                                end
                            end
                            CMD_DELETE, CMD_GET:
                            begin
                                if (range_bad)
                                begin
                                    done_reg   <= 1'b1;
                                    ok_reg     <= 1'b0;
                                    status_reg <= ST_RANGE;
                                end
                                else
                                begin
                                    done_reg   <= 1'b0;
                                    ok_reg     <= 1'b0;
                                    status_reg <= ST_OK;
                                    state_reg  <= S_FETCH;
                                end
                            end
                            CMD_CLEAR:
                            begin
                                count_reg  <= '0;
                                done_reg   <= 1'b1;
                                ok_reg     <= 1'b1;
                                status_reg <= ST_OK;
                            end
                            default:
                            begin
                                done_reg   <= 1'b1;
                                ok_reg     <= 1'b0;
                                status_reg <= ST_RANGE;
                            end
                        endcase
                    end
                    else
                    begin
                        done_reg <= 1'b0;
                    end
                end
                S_FETCH:
                begin
                    // hold the removed entry while the gap closes
                    hold_reg   <= ram_rdata;
                    ok_reg     <= 1'b1;
                    status_reg <= ST_OK;
                    read_reg   <= rd_ext[VAL_WIDTH-1:0];
                    if ((cmd_reg == CMD_DELETE) && shift_reg)
                    begin
                        done_reg  <= 1'b0;
                        state_reg <= S_MOVE;
                        pend_reg  <= 1'b0;
                    end
                    else
                    begin
                        if (cmd_reg == CMD_DELETE)
                        begin
                            count_reg <= count_reg - CW'(1);
                        end
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_MOVE:
                begin
                    done_reg <= 1'b0;
                    pend_reg <= 1'b1;
                    if (up_reg)
                    begin
                        rp_reg <= rp_reg - AW'(1);
                        wa_reg <= rp_reg + AW'(1);
                    end
                    else
                    begin
                        rp_reg <= rp_reg + AW'(1);
                        wa_reg <= rp_reg - AW'(1);
                    end
                    if (rp_reg == last_reg)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    pend_reg <= 1'b0;
                    if (up_reg)
                    begin
                        done_reg  <= 1'b0;
                        state_reg <= S_PLACE;
                    end
                    else
                    begin
                        count_reg  <= count_reg - CW'(1);
                        done_reg   <= 1'b1;
                        state_reg  <= S_IDLE;
                        ok_reg     <= 1'b1;
                        status_reg <= ST_OK;
                        read_reg   <= hold_ext[VAL_WIDTH-1:0];
                    end
                end
                S_PLACE:
                begin
                    count_reg  <= count_reg + CW'(1);
                    done_reg   <= 1'b1;
                    state_reg  <= S_IDLE;
                    ok_reg     <= 1'b1;
                    status_reg <= ST_OK;
                    read_reg   <= '0;
                end
                default:
                begin
                    done_reg  <= 1'b0;
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `PAL_ASSERT(a_done_not_busy, done |-> !busy, "result issued while busy")
    `PAL_ASSERT(a_ok_matches_status, done |-> (ok == (status == ST_OK)),
        "ok disagrees with status")
    `PAL_ASSERT(a_fail_reads_zero, (done && !ok) |-> (read_value == '0),
        "failed result carries data")
    `PAL_ASSERT(a_clear_empties,
        (accept && (command == CMD_CLEAR)) |=> (done && (list_length == '0)),
        "clear did not empty")
    `PAL_NEVER(a_count_bound, count_x > depth_x, "length exceeds store depth")

endmodule
